[hw/rtl/metronome_click_mixer_macros.svh]
// Assertion macros of the metronome click mixer checker.
`ifndef METRONOME_CLICK_MIXER_MACROS_SVH
`define METRONOME_CLICK_MIXER_MACROS_SVH

// Clocked check, muted while reset is asserted.
`define MCM_ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define MCM_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/mcm_pkg.sv]
// Shared constants, types and the click sine table of the metronome click mixer.
package mcm_pkg;

	localparam int PHASE_BITS     = 24;
	localparam int SAMPLE_BITS    = 16;
	localparam int TABLE_BITS     = 10;
	localparam int COUNT_BITS     = 20;
	localparam int STEP_BITS      = 23;
	localparam int BAR_BITS       = 4;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 23;
	localparam int QUARTER_BITS   = TABLE_BITS - 2;
	localparam int QUARTER        = 1 << QUARTER_BITS;
	localparam int QUEUE_DEPTH    = 4;
	localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);

	// Register indexes of the configuration port
	localparam logic [CFG_INDEX_BITS-1:0] REG_BEAT_PERIOD   = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PING_LENGTH   = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ACCENT_STEP   = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_NORMAL_STEP   = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BEATS_PER_BAR = 3'd4;

	// Reset values of the registers
	localparam logic [COUNT_BITS-1:0] BEAT_PERIOD_RST   = 20'd24000;
	localparam logic [COUNT_BITS-1:0] PING_LENGTH_RST   = 20'd9600;
	localparam logic [STEP_BITS-1:0]  ACCENT_STEP_RST   = 23'd83886;
	localparam logic [STEP_BITS-1:0]  NORMAL_STEP_RST   = 23'd62915;
	localparam logic [BAR_BITS-1:0]   BEATS_PER_BAR_RST = 4'd4;

	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam longint unsigned CLICK_AMP   = ((64'd1 << (SAMPLE_BITS - 1)) - 64'd1) / 64'd3;
	localparam longint unsigned ONE_Q30     = 64'd1 << 30;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// One sample word handed from the front to the back
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left;
		logic signed [SAMPLE_BITS-1:0] right;
		logic                          tone;
		logic [TABLE_BITS-1:0]         idx;
	} word_t;

	// Queue status seen by the front and back
	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	typedef logic [SAMPLE_BITS-1:0] quarter_tab_t [QUARTER];

	// sin(x) on [0, pi/2], Q30 in and out, nested Taylor terms up to x^11
	function automatic logic [63:0] sin_q30(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] t;
		x2 = (x * x) >> 30;
		t = ONE_Q30 - x2 / 64'd110;
		t = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
		t = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
		t = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
		t = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
		return (x * t) >> 30;
	endfunction

	// Click magnitude at quarter-wave position m (0 .. QUARTER)
	function automatic logic [SAMPLE_BITS-1:0] quarter_entry(input int unsigned m);
		logic [63:0] x;
		logic [63:0] s;
		logic [63:0] v;
		x = (64'(HALF_PI_Q30) * 64'(m)) / 64'(QUARTER);
		s = sin_q30(x);
		if (s > ONE_Q30) s = ONE_Q30;
		v = (s * 64'(CLICK_AMP)) >> 30;
		return v[SAMPLE_BITS-1:0];
	endfunction

	function automatic quarter_tab_t build_quarter();
		quarter_tab_t tab;
		for (int unsigned m = 0; m < QUARTER; m++) begin
			tab[m] = quarter_entry(m);
		end
		return tab;
	endfunction

	localparam quarter_tab_t QUARTER_TAB = build_quarter();
	localparam logic [SAMPLE_BITS-1:0] PEAK_VALUE = quarter_entry(QUARTER);

endpackage

[hw/rtl/mcm_front.sv]
// Front end: configuration registers, word classification and beat/phase sequencing.
module mcm_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [2*mcm_pkg::SAMPLE_BITS-1:0]    s_tdata,  // left_in, right_in
	input  logic                                 s_tuser,  // func
	input  logic                                 cfg_we,
	input  logic [mcm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [mcm_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  mcm_pkg::queue_stat_t                 qstat,
	output logic                                 push,
	output mcm_pkg::word_t                       push_word
);

	logic [mcm_pkg::COUNT_BITS-1:0] beat_period_q, ping_length_q;
	logic [mcm_pkg::STEP_BITS-1:0]  accent_step_q, normal_step_q;
	logic [mcm_pkg::BAR_BITS-1:0]   beats_per_bar_q;

	logic                           pinging_q, tone_active_q, accent_q;
	logic [mcm_pkg::COUNT_BITS-1:0] pos_q;
	logic [mcm_pkg::PHASE_BITS-1:0] phase_q;
	logic [mcm_pkg::BAR_BITS-1:0]   pib_q;

	logic                           pinging_d, tone_active_d, accent_d;
	logic [mcm_pkg::COUNT_BITS-1:0] pos_d, pos_inc;
	logic [mcm_pkg::PHASE_BITS-1:0] phase_d;
	logic [mcm_pkg::BAR_BITS-1:0]   pib_d, pib_inc;
	logic [mcm_pkg::STEP_BITS-1:0]  step;
	logic                           accept;

	assign s_tready = !qstat.full;
	assign accept   = s_tvalid && !qstat.full;
	assign push     = accept && !s_tuser;

	assign step    = accent_q ? accent_step_q : normal_step_q;
	assign pos_inc = pos_q + 1'b1;
	assign pib_inc = pib_q + 1'b1;

	always_comb begin
		push_word.left  = s_tdata[mcm_pkg::SAMPLE_BITS-1:0];
		push_word.right = s_tdata[2*mcm_pkg::SAMPLE_BITS-1:mcm_pkg::SAMPLE_BITS];
		push_word.tone  = pinging_q && tone_active_q;
		push_word.idx   = phase_q[mcm_pkg::PHASE_BITS-1 -: mcm_pkg::TABLE_BITS];
	end

	always_comb begin
		pinging_d     = pinging_q;
		tone_active_d = tone_active_q;
		accent_d      = accent_q;
		pos_d         = pos_q;
		phase_d       = phase_q;
		pib_d         = pib_q;
		if (accept && s_tuser) begin
			if (!pinging_q) begin
				pinging_d     = 1'b1;
				tone_active_d = 1'b1;
				accent_d      = 1'b1;
				pos_d         = '0;
				phase_d       = '0;
				pib_d         = '0;
			end else begin
				pinging_d     = 1'b0;
				tone_active_d = 1'b0;
			end
		end else if (accept && pinging_q) begin
			if (tone_active_q) begin
				phase_d = phase_q +
					{{(mcm_pkg::PHASE_BITS-mcm_pkg::STEP_BITS){1'b0}}, step};
			end
			pos_d = pos_inc;
			if (pos_inc == beat_period_q) begin
				pos_d         = '0;
				phase_d       = '0;
				tone_active_d = 1'b1;
			end else if (pos_inc == ping_length_q) begin
				// end of ping: count it and pick the tone of the next one
				if (pib_inc == beats_per_bar_q) begin
					pib_d    = '0;
					accent_d = 1'b1;
				end else begin
					pib_d    = pib_inc;
					accent_d = 1'b0;
				end
				tone_active_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_period_q   <= mcm_pkg::BEAT_PERIOD_RST;
			ping_length_q   <= mcm_pkg::PING_LENGTH_RST;
			accent_step_q   <= mcm_pkg::ACCENT_STEP_RST;
			normal_step_q   <= mcm_pkg::NORMAL_STEP_RST;
			beats_per_bar_q <= mcm_pkg::BEATS_PER_BAR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				mcm_pkg::REG_BEAT_PERIOD:   beat_period_q   <= cfg_data[mcm_pkg::COUNT_BITS-1:0];
				mcm_pkg::REG_PING_LENGTH:   ping_length_q   <= cfg_data[mcm_pkg::COUNT_BITS-1:0];
				mcm_pkg::REG_ACCENT_STEP:   accent_step_q   <= cfg_data[mcm_pkg::STEP_BITS-1:0];
				mcm_pkg::REG_NORMAL_STEP:   normal_step_q   <= cfg_data[mcm_pkg::STEP_BITS-1:0];
				mcm_pkg::REG_BEATS_PER_BAR: beats_per_bar_q <= cfg_data[mcm_pkg::BAR_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pinging_q     <= 1'b0;
			tone_active_q <= 1'b0;
			accent_q      <= 1'b1;
			pos_q         <= '0;
			phase_q       <= '0;
			pib_q         <= '0;
		end else begin
			pinging_q     <= pinging_d;
			tone_active_q <= tone_active_d;
			accent_q      <= accent_d;
			pos_q         <= pos_d;
			phase_q       <= phase_d;
			pib_q         <= pib_d;
		end
	end

endmodule

[hw/rtl/mcm_queue.sv]
// Short word queue between the front and back ends.
module mcm_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  mcm_pkg::word_t       push_word,
	input  logic                 pop,
	output mcm_pkg::queue_stat_t qstat,
	output mcm_pkg::word_t       head
);

	mcm_pkg::word_t               mem_q [mcm_pkg::QUEUE_DEPTH];
	logic [mcm_pkg::QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [mcm_pkg::QPTR_BITS:0]   count_q;

	assign qstat.full  = (count_q == (mcm_pkg::QPTR_BITS+1)'(mcm_pkg::QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign head        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hw/rtl/mcm_back.sv]
// Back end: sine lookup, click mix with saturation and the output register.
module mcm_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mcm_pkg::queue_stat_t              qstat,
	input  mcm_pkg::word_t                    head,
	output logic                              pop,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [2*mcm_pkg::SAMPLE_BITS-1:0] m_tdata,  // left_out, right_out
	output logic                              m_tuser   // tone_on
);

	logic                                  valid_s1;
	logic signed [mcm_pkg::SAMPLE_BITS-1:0] left_s1, right_s1, click_s1;
	logic                                  tone_s1;

	logic                                  out_valid_q;
	logic signed [mcm_pkg::SAMPLE_BITS-1:0] left_q, right_q;
	logic                                  tone_q;

	logic                                  adv;
	logic [1:0]                            quad;
	logic [mcm_pkg::QUARTER_BITS-1:0]      r, r_m;
	logic [mcm_pkg::SAMPLE_BITS-1:0]       mag, click;
	logic signed [mcm_pkg::SAMPLE_BITS:0]  sum_l, sum_r;

	function automatic logic [mcm_pkg::SAMPLE_BITS-1:0] sat(
		input logic signed [mcm_pkg::SAMPLE_BITS:0] v);
		if (v[mcm_pkg::SAMPLE_BITS] != v[mcm_pkg::SAMPLE_BITS-1]) begin
			return v[mcm_pkg::SAMPLE_BITS] ? mcm_pkg::SAMPLE_MIN : mcm_pkg::SAMPLE_MAX;
		end
		return v[mcm_pkg::SAMPLE_BITS-1:0];
	endfunction

	assign adv = !out_valid_q || m_tready;
	assign pop = adv && !qstat.empty;

	// Quarter-wave symmetry: mirror odd quadrants, negate the lower half-wave
	always_comb begin
		quad = head.idx[mcm_pkg::TABLE_BITS-1 -: 2];
		r    = head.idx[mcm_pkg::QUARTER_BITS-1:0];
		r_m  = quad[0] ? (~r + 1'b1) : r;
		if (quad[0] && r == '0) begin
			mag = mcm_pkg::PEAK_VALUE;
		end else begin
			mag = mcm_pkg::QUARTER_TAB[r_m];
		end
		if (!head.tone) begin
			click = '0;
		end else if (quad[1]) begin
			click = '0 - mag;
		end else begin
			click = mag;
		end
	end

	assign sum_l = {left_s1[mcm_pkg::SAMPLE_BITS-1], left_s1} +
		{click_s1[mcm_pkg::SAMPLE_BITS-1], click_s1};
	assign sum_r = {right_s1[mcm_pkg::SAMPLE_BITS-1], right_s1} +
		{click_s1[mcm_pkg::SAMPLE_BITS-1], click_s1};

	always_ff @(posedge clk) begin
		if (pop) begin
			left_s1  <= head.left;
			right_s1 <= head.right;
			click_s1 <= click;
			tone_s1  <= head.tone;
		end
		if (adv && valid_s1) begin
			left_q  <= sat(sum_l);
			right_q <= sat(sum_r);
			tone_q  <= tone_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= !qstat.empty;
			out_valid_q <= valid_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {right_q, left_q};
	assign m_tuser  = tone_q;

endmodule

[hw/rtl/metronome_click_mixer.sv]
// A sample word passes through the queue, the stage-one register and the output register.
// One word per cycle unless the queue is full; a toggle word is taken but yields no word.
// The front end's beat/phase registers and the four-entry queue set the one-word rate.
// Reset (arst_n low, asynchronous): pass-through, accent tone, counters and phase zero,
// registers at their defaults, queue and output empty.
module metronome_click_mixer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// slave side
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [2*mcm_pkg::SAMPLE_BITS-1:0]    s_tdata,   // left_in [15:0], right_in [31:16]
	input  logic                                 s_tuser,   // func: 0 sample pair, 1 toggle
	// master side
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [2*mcm_pkg::SAMPLE_BITS-1:0]    m_tdata,   // left_out [15:0], right_out [31:16]
	output logic                                 m_tuser,   // tone_on
	// configuration writes
	input  logic                                 cfg_we,
	input  logic [mcm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [mcm_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	// Front to queue: one word per accepted sample pair, with the click phase index
	logic                 push;
	mcm_pkg::word_t       push_word;
	// Queue to back: head word and fill status
	logic                 pop;
	mcm_pkg::word_t       head;
	mcm_pkg::queue_stat_t qstat;

	// Classify words, apply toggles and advance beat, ping and phase state
	mcm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.qstat     (qstat),
		.push      (push),
		.push_word (push_word)
	);

	// Decouple the two ends so a stalled master side backs up here first
	mcm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.qstat     (qstat),
		.head      (head)
	);

	// Look up the sine, add it to both channels with saturation, hold for the master side
	mcm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qstat    (qstat),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

[hw/rtl/mcm_checker.sv]
// Port-level checks of the metronome click mixer, bound to the top level.
`include "metronome_click_mixer_macros.svh"

module mcm_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic [2*mcm_pkg::SAMPLE_BITS-1:0] s_tdata,
	input logic                              s_tuser,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [2*mcm_pkg::SAMPLE_BITS-1:0] m_tdata,
	input logic                              m_tuser,
	input logic                              cfg_we,
	input logic [mcm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input logic [mcm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	// A stalled output word holds its value
	`MCM_ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output word changed while stalled")

	// During reset the output is empty and the input side is open
	`MCM_ASSERT_RST(a_reset_state, !arst_n |-> !m_tvalid && s_tready, "bad port state in reset")

	// The input side closes only when the queue backs up behind a waiting output word
	`MCM_ASSERT_CLK(a_backpressure, !s_tready |-> m_tvalid, "input stalled with no output word pending")

	// A waiting input word holds its value until taken
	`MCM_ASSERT_CLK(a_in_hold, s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser), "input word changed while waiting")

	// Register writes must land only while no word is in flight at the ports; the design does not enforce it.
	`MCM_ASSERT_CLK(a_cfg_quiet, cfg_we |-> !s_tvalid && !m_tvalid && !$isunknown({cfg_index, cfg_data}), "register write while words in flight")

endmodule

bind metronome_click_mixer mcm_checker u_mcm_checker (.*);

[tb/tb.sv]
// Self-checking testbench of the metronome click mixer: directed table, then random phases.
`timescale 1ns / 1ps

module tb;

	localparam int SB = mcm_pkg::SAMPLE_BITS;
	localparam int PB = mcm_pkg::PHASE_BITS;
	localparam int TB_BITS = mcm_pkg::TABLE_BITS;
	localparam int WAVE_SIZE = 1 << TB_BITS;
	localparam int QUARTER_SIZE = WAVE_SIZE / 4;

	// What a slave-side word carries in tuser
	localparam logic FN_SAMPLE = 1'b0;
	localparam logic FN_TOGGLE = 1'b1;

	// Fixed-point constants of the click sine
	localparam longint unsigned Q30_ONE = 64'd1 << 30;
	localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
	localparam longint unsigned CLICK_PEAK = ((64'd1 << (SB - 1)) - 64'd1) / 64'd3;

	// Cycles to let pass after the last word before touching the registers
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASE_WORDS = 155;
	localparam int FIXED_SETS = 8;
	localparam int RANDOM_SETS = 4;

	localparam logic [mcm_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_LO = mcm_pkg::REG_BEATS_PER_BAR + 1'b1;
	localparam logic [mcm_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_HI = '1;

	typedef struct packed {
		logic signed [SB-1:0] left;
		logic signed [SB-1:0] right;
		logic                 tone;
	} mix_word_t;

	typedef struct packed {
		logic                 fn;
		logic signed [SB-1:0] left;
		logic signed [SB-1:0] right;
		logic                 typed;
		logic signed [SB-1:0] exp_left;
		logic signed [SB-1:0] exp_right;
		logic                 exp_tone;
	} click_row_t;

	typedef struct packed {
		logic [mcm_pkg::CFG_DATA_BITS-1:0] beat;
		logic [mcm_pkg::CFG_DATA_BITS-1:0] ping;
		logic [mcm_pkg::CFG_DATA_BITS-1:0] accent;
		logic [mcm_pkg::CFG_DATA_BITS-1:0] normal;
		logic [mcm_pkg::CFG_DATA_BITS-1:0] bars;
	} tempo_set_t;

	logic                               clk;
	logic                               arst_n    = 1'b1;
	logic                               s_tvalid  = 1'b0;
	logic                               s_tready;
	logic [2*SB-1:0]                    s_tdata   = '0;  // left_in [15:0], right_in [31:16]
	logic                               s_tuser   = 1'b0; // func: 0 sample pair, 1 toggle
	logic                               m_tvalid;
	logic                               m_tready  = 1'b0;
	logic [2*SB-1:0]                    m_tdata;         // left_out [15:0], right_out [31:16]
	logic                               m_tuser;         // tone_on
	logic                               cfg_we    = 1'b0;
	logic [mcm_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [mcm_pkg::CFG_DATA_BITS-1:0]  cfg_data  = '0;

	metronome_click_mixer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ---------------------------------------------------------------------------------
	// Click predictor: register shadow, beat/ping state and the one-third-scale sine
	// ---------------------------------------------------------------------------------
	logic [mcm_pkg::COUNT_BITS-1:0] beat_len   = mcm_pkg::BEAT_PERIOD_RST;
	logic [mcm_pkg::COUNT_BITS-1:0] ping_len   = mcm_pkg::PING_LENGTH_RST;
	logic [mcm_pkg::STEP_BITS-1:0]  acc_step   = mcm_pkg::ACCENT_STEP_RST;
	logic [mcm_pkg::STEP_BITS-1:0]  norm_step  = mcm_pkg::NORMAL_STEP_RST;
	logic [mcm_pkg::BAR_BITS-1:0]   bar_len    = mcm_pkg::BEATS_PER_BAR_RST;

	logic                           clicking   = 1'b0;
	logic                           ping_live  = 1'b0;
	logic                           accent_sel = 1'b1;
	logic [mcm_pkg::COUNT_BITS-1:0] beat_ctr   = '0;
	logic [PB-1:0]                  phase_acc  = '0;
	logic [mcm_pkg::BAR_BITS-1:0]   bar_count  = '0;

	logic signed [SB-1:0] click_wave [WAVE_SIZE];

	// Expected mixer output words, oldest first
	mix_word_t mixed_q[$];

	int fail_count     = 0;
	int src_idle_pct   = 0;
	int sink_stall_pct = 0;

	// Odd-power series for sin on [0, pi/2], Q30 fixed point, Horner form down from x^11
	function automatic longint unsigned sine_q30(input longint unsigned ang);
		longint unsigned sq;
		longint unsigned acc;
		sq  = (ang * ang) >> 30;
		acc = Q30_ONE - sq / 110;
		acc = Q30_ONE - ((sq * acc) >> 30) / 72;
		acc = Q30_ONE - ((sq * acc) >> 30) / 42;
		acc = Q30_ONE - ((sq * acc) >> 30) / 20;
		acc = Q30_ONE - ((sq * acc) >> 30) / 6;
		return (ang * acc) >> 30;
	endfunction

	// Full wave from one quarter: mirror odd quadrants, negate the second half
	function automatic void fill_click_wave();
		int unsigned quad;
		int unsigned pos;
		int unsigned mirrored;
		longint unsigned s;
		longint signed mag;
		for (int k = 0; k < WAVE_SIZE; k++) begin
			quad     = k / QUARTER_SIZE;
			pos      = k % QUARTER_SIZE;
			mirrored = quad[0] ? QUARTER_SIZE - pos : pos;
			s = sine_q30((Q30_HALF_PI * mirrored) / QUARTER_SIZE);
			if (s > Q30_ONE)
				s = Q30_ONE;
			mag = longint'((s * CLICK_PEAK) >> 30);
			click_wave[k] = (quad >= 2) ? SB'(-mag) : SB'(mag);
		end
	endfunction

	function automatic logic signed [SB-1:0] clamp_sample(input int v);
		if (v > int'(mcm_pkg::SAMPLE_MAX))
			return mcm_pkg::SAMPLE_MAX;
		if (v < int'(mcm_pkg::SAMPLE_MIN))
			return mcm_pkg::SAMPLE_MIN;
		return SB'(v);
	endfunction

	// Advance the predictor by one accepted word; returns 1 when a mixed word follows
	function automatic bit step_click(input logic fn, input logic signed [SB-1:0] l,
			input logic signed [SB-1:0] r, output mix_word_t w);
		logic signed [SB-1:0] click;
		click = '0;
		w     = '0;
		if (fn == FN_TOGGLE) begin
			if (!clicking) begin
				// start pinging: fresh bar, accent tone, phase zero
				clicking   = 1'b1;
				ping_live  = 1'b1;
				accent_sel = 1'b1;
				beat_ctr   = '0;
				phase_acc  = '0;
				bar_count  = '0;
			end else begin
				clicking  = 1'b0;
				ping_live = 1'b0;
			end
			return 1'b0;
		end
		if (clicking) begin
			if (ping_live) begin
				click     = click_wave[phase_acc[PB-1 -: TB_BITS]];
				w.tone    = 1'b1;
				phase_acc = phase_acc + (accent_sel ? acc_step : norm_step);
			end
			beat_ctr = beat_ctr + 1'b1;
			if (beat_ctr == beat_len) begin
				// next beat: restart the ping from phase zero
				beat_ctr  = '0;
				phase_acc = '0;
				ping_live = 1'b1;
			end else if (beat_ctr == ping_len) begin
				// ping over: pick the tone of the next beat
				bar_count = bar_count + 1'b1;
				if (bar_count == bar_len) begin
					bar_count  = '0;
					accent_sel = 1'b1;
				end else begin
					accent_sel = 1'b0;
				end
				ping_live = 1'b0;
			end
		end
		w.left  = clamp_sample(int'(l) + int'(click));
		w.right = clamp_sample(int'(r) + int'(click));
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------------------------
	// Clock, receiver back-pressure and a hard limit on the run
	// ---------------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	initial begin
		#2_000_000;
		$display("tb NOT OK");
		$finish;
	end

	// ---------------------------------------------------------------------------------
	// Output checker: compare each accepted word with the oldest expectation
	// ---------------------------------------------------------------------------------
	always @(posedge clk) begin
		mix_word_t want;
		if (m_tvalid && m_tready) begin
			if (mixed_q.size() == 0) begin
				$error("word with none expected: left_out %0d right_out %0d tone_on %0b",
					$signed(m_tdata[SB-1:0]), $signed(m_tdata[2*SB-1:SB]), m_tuser);
				fail_count++;
			end else begin
				want = mixed_q.pop_front();
				if (m_tdata[SB-1:0] !== want.left) begin
					$error("left_out: expected %0d, got %0d", want.left,
						$signed(m_tdata[SB-1:0]));
					fail_count++;
				end
				if (m_tdata[2*SB-1:SB] !== want.right) begin
					$error("right_out: expected %0d, got %0d", want.right,
						$signed(m_tdata[2*SB-1:SB]));
					fail_count++;
				end
				if (m_tuser !== want.tone) begin
					$error("tone_on: expected %0b, got %0b", want.tone, m_tuser);
					fail_count++;
				end
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------------------------

	// Offer one word and hold it until taken; call at a rising edge.
	// A typed row replaces the predicted word by the one written in the table.
	task automatic send_word(input logic fn, input logic signed [SB-1:0] l,
			input logic signed [SB-1:0] r, input bit typed = 1'b0,
			input mix_word_t typed_word = '0);
		mix_word_t w;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {r, l};
		s_tuser  <= fn;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		// taken at this edge: predict now, valid stays up for a following word
		if (step_click(fn, l, r, w))
			mixed_q.push_back(typed ? typed_word : w);
	endtask

	// Drop valid, wait out every expected word and the pipeline tail
	task automatic settle_mixer();
		s_tvalid <= 1'b0;
		while (mixed_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write; the shadow follows with the same masking
	task automatic write_reg(input logic [mcm_pkg::CFG_INDEX_BITS-1:0] idx,
			input logic [mcm_pkg::CFG_DATA_BITS-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			mcm_pkg::REG_BEAT_PERIOD:   beat_len  = data[mcm_pkg::COUNT_BITS-1:0];
			mcm_pkg::REG_PING_LENGTH:   ping_len  = data[mcm_pkg::COUNT_BITS-1:0];
			mcm_pkg::REG_ACCENT_STEP:   acc_step  = data[mcm_pkg::STEP_BITS-1:0];
			mcm_pkg::REG_NORMAL_STEP:   norm_step = data[mcm_pkg::STEP_BITS-1:0];
			mcm_pkg::REG_BEATS_PER_BAR: bar_len   = data[mcm_pkg::BAR_BITS-1:0];
			default: ;  // unused index: the block ignores it
		endcase
	endtask

	// Random sample: uniform half the time, otherwise close to either rail
	function automatic logic signed [SB-1:0] pick_level();
		case ($urandom_range(0, 3))
			0: return SB'(32767 - $urandom_range(0, 12000));
			1: return SB'(-32768 + $urandom_range(0, 12000));
			default: return SB'($urandom);
		endcase
	endfunction

	// ---------------------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------------------
	localparam int ROWS = 22;

	// Directed words at the reset settings: pass-through rails, toggles, first ping sample
	click_row_t rows [ROWS] = '{
		'{FN_SAMPLE, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0, 1'b0},
		'{FN_SAMPLE, 16'sd32767, -16'sd32768, 1'b1, 16'sd32767, -16'sd32768, 1'b0},
		'{FN_SAMPLE, -16'sd32768, 16'sd32767, 1'b1, -16'sd32768, 16'sd32767, 1'b0},
		'{FN_SAMPLE, 16'sd21845, -16'sd21846, 1'b1, 16'sd21845, -16'sd21846, 1'b0},
		'{FN_SAMPLE, -16'sd1, 16'sd1, 1'b1, -16'sd1, 16'sd1, 1'b0},
		// pinging on: the first sample gets the tone at phase zero, which adds nothing
		'{FN_TOGGLE, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0, 1'b0},
		'{FN_SAMPLE, 16'sd32767, -16'sd32768, 1'b1, 16'sd32767, -16'sd32768, 1'b1},
		'{FN_SAMPLE, 16'sd32767, 16'sd32767, 1'b0, 16'sd0, 16'sd0, 1'b0},
		'{FN_SAMPLE, 16'sd32767, 16'sd32767, 1'b0, 16'sd0, 16'sd0, 1'b0},
		'{FN_SAMPLE, -16'sd32768, -16'sd32768, 1'b0, 16'sd0, 16'sd0, 1'b0},
		'{FN_SAMPLE, 16'sd1000, -16'sd1000, 1'b0, 16'sd0, 16'sd0, 1'b0},
		'{FN_TOGGLE, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0, 1'b0},
		'{FN_SAMPLE, 16'sd100, -16'sd100, 1'b1, 16'sd100, -16'sd100, 1'b0},
		// on and straight off again
		'{FN_TOGGLE, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0, 1'b0},
		'{FN_TOGGLE, -16'sd1, -16'sd1, 1'b0, 16'sd0, 16'sd0, 1'b0},
		'{FN_SAMPLE, 16'sd7, -16'sd7, 1'b1, 16'sd7, -16'sd7, 1'b0},
		'{FN_TOGGLE, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0, 1'b0},
		'{FN_SAMPLE, -16'sd32768, 16'sd32767, 1'b1, -16'sd32768, 16'sd32767, 1'b1},
		'{FN_SAMPLE, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0, 1'b0},
		'{FN_SAMPLE, 16'sd12345, -16'sd12345, 1'b0, 16'sd0, 16'sd0, 1'b0},
		'{FN_TOGGLE, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0, 1'b0},
		'{FN_SAMPLE, 16'sd32767, -16'sd32768, 1'b1, 16'sd32767, -16'sd32768, 1'b0}
	};

	// Register settings: steps at the rails, one-sample beats, pings as long as or
	// longer than the beat, no or fifteen beats per bar, zero beat period, and
	// wide data that the 20- and 4-bit registers must truncate
	tempo_set_t fixed_sets [FIXED_SETS] = '{
		'{23'd8, 23'd3, 23'h7FFFFF, 23'd0, 23'd4},
		'{23'd1, 23'd1, 23'd12345, 23'd54321, 23'd1},
		'{23'd5, 23'd5, 23'd400000, 23'd300000, 23'd3},
		'{23'd6, 23'd20, 23'd1000000, 23'd2000000, 23'd2},
		'{23'd7, 23'd2, 23'd3000000, 23'd5000000, 23'd0},
		'{23'd9, 23'd4, 23'h7FFFFF, 23'h400000, 23'd15},
		'{23'd0, 23'd3, 23'd700000, 23'd1, 23'd4},
		'{23'h7FFFFF, 23'hFFFFF, 23'd0, 23'h7FFFFF, 23'h7FFFF3}
	};

	int idle_src [4]   = '{0, 52, 0, 13};
	int stall_sink [4] = '{0, 0, 52, 13};

	initial begin
		tempo_set_t ts;
		logic       fn;
		arst_n <= 1'b0;
		fill_click_wave();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, no idling on either side
		for (int i = 0; i < ROWS; i++) begin
			send_word(rows[i].fn, rows[i].left, rows[i].right, rows[i].typed,
				'{rows[i].exp_left, rows[i].exp_right, rows[i].exp_tone});
		end

		// random phases, each with its own register setting and idling mix
		for (int p = 0; p < FIXED_SETS + RANDOM_SETS; p++) begin
			settle_mixer();
			if (p < FIXED_SETS) begin
				ts = fixed_sets[p];
			end else begin
				ts.beat   = mcm_pkg::CFG_DATA_BITS'($urandom_range(1, 48));
				ts.ping   = mcm_pkg::CFG_DATA_BITS'($urandom_range(1, 48));
				ts.accent = mcm_pkg::CFG_DATA_BITS'($urandom);
				ts.normal = mcm_pkg::CFG_DATA_BITS'($urandom);
				ts.bars   = mcm_pkg::CFG_DATA_BITS'($urandom_range(0, 15));
			end
			write_reg(mcm_pkg::REG_BEAT_PERIOD, ts.beat);
			write_reg(mcm_pkg::REG_PING_LENGTH, ts.ping);
			write_reg(mcm_pkg::REG_ACCENT_STEP, ts.accent);
			write_reg(mcm_pkg::REG_NORMAL_STEP, ts.normal);
			write_reg(mcm_pkg::REG_BEATS_PER_BAR, ts.bars);
			write_reg(mcm_pkg::CFG_INDEX_BITS'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
				mcm_pkg::CFG_DATA_BITS'($urandom));
			src_idle_pct   = idle_src[p % 4];
			sink_stall_pct = stall_sink[p % 4];

			for (int n = 0; n < PHASE_WORDS; n++) begin
				// mostly pinging: turn on soon when off, turn off rarely
				if (clicking)
					fn = ($urandom_range(0, 99) < 2) ? FN_TOGGLE : FN_SAMPLE;
				else
					fn = ($urandom_range(0, 99) < 30) ? FN_TOGGLE : FN_SAMPLE;
				send_word(fn, pick_level(), pick_level());
			end
		end

		settle_mixer();
		if (fail_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
